// File: rtl/bmf_pkg.sv
// Shared types, constants and divisor tables for the 3x3 box mean filter.
package bmf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 8;
  localparam int FRAC_BITS   = 8;

  localparam int COL_BITS        = $clog2(MAX_WIDTH);
  localparam int ROW_BITS        = 16;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 16;
  localparam int MEAN_BITS       = 16;
  localparam int CNT_BITS        = 4;

  localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = CFG_WIDTH_BITS'(256);
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = CFG_HEIGHT_BITS'(256);
  localparam logic [MEAN_BITS-1:0]       MEAN_MAX     = '1;

  // sum of up to nine samples, then scaled by the fraction bits
  localparam int SUM_BITS   = SAMPLE_BITS + 4;
  localparam int NUM_BITS   = SUM_BITS + FRAC_BITS;
  localparam int DIV_SHIFT  = NUM_BITS + 3;
  localparam int RECIP_BITS = DIV_SHIFT + 1;
  localparam int PROD_BITS  = NUM_BITS + RECIP_BITS;

  localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(64'd1 << DIV_SHIFT);
  localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(64'd1 << (DIV_SHIFT - 1));
  localparam logic [RECIP_BITS-1:0] RECIP_3 =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
  localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(64'd1 << (DIV_SHIFT - 2));
  localparam logic [RECIP_BITS-1:0] RECIP_6 =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6);
  localparam logic [RECIP_BITS-1:0] RECIP_9 =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] count;
    logic                frame_last;
    logic                dropped;
  } stage_t;

  function automatic logic [RECIP_BITS-1:0] recip_of(input logic [CNT_BITS-1:0] n);
    logic [RECIP_BITS-1:0] r;
    unique case (n)
      CNT_BITS'(1): r = RECIP_1;
      CNT_BITS'(2): r = RECIP_2;
      CNT_BITS'(3): r = RECIP_3;
      CNT_BITS'(4): r = RECIP_4;
      CNT_BITS'(6): r = RECIP_6;
      CNT_BITS'(9): r = RECIP_9;
      default:      r = RECIP_1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/bmf_in_if.sv
// Input item channel: operation and height sample.
interface bmf_in_if import bmf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

// File: rtl/bmf_out_if.sv
// Result item channel: mean value with frame and drop flags.
interface bmf_out_if import bmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MEAN_BITS-1:0] mean_value;
  logic                 frame_last;
  logic                 dropped;

  modport source (output valid, output mean_value, output frame_last, output dropped,
                  input ready);
  modport sink   (input valid, input mean_value, input frame_last, input dropped,
                  output ready);
endinterface

// File: rtl/bmf_cfg_if.sv
// Register write channel: register index and write data.
interface bmf_cfg_if import bmf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  reg_index_t               index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/bmf_ram.sv
// Generic simple dual-port RAM with registered read (old data on collision).
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: rtl/bmf_window.sv
// Raster counters, line buffers, 3x3 window and masked neighborhood sum.
module bmf_window import bmf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  bmf_in_if.sink stream,
  bmf_cfg_if.sink setup,
  output logic   stage_valid,
  output stage_t stage,
  input  logic   stage_ready
);

  logic [CFG_WIDTH_BITS-1:0]  frame_width;
  logic [CFG_HEIGHT_BITS-1:0] frame_height;
  logic [COL_BITS-1:0]        w_last;
  logic [ROW_BITS-1:0]        h_last;
  logic                       single_row;

  logic [COL_BITS-1:0] in_col, in_col_next, out_col, out_col_next, rd_addr;
  logic [ROW_BITS-1:0] in_row, in_row_next, out_row, out_row_next;
  logic                draining, draining_next;

  logic [SAMPLE_BITS-1:0] col0, col0_val;
  logic [SAMPLE_BITS-1:0] win_u0, win_m0, win_v0, win_u1, win_m1, win_v1;
  logic [SAMPLE_BITS-1:0] ram_u, ram_m, u_eff, m_eff, v_in;
  logic                   byp_hit;
  logic [SAMPLE_BITS-1:0] byp_u, byp_m;

  logic fire, cfg_fire, is_sample, release_pt, final_in, out_final;
  logic do_arrive, do_write, emit, dropped_res, adv_out, last_res, restart;
  logic r_lo, r_hi, c_lo, c_hi;
  logic [SUM_BITS-1:0] cs0, cs1, cs2, sum;
  logic [1:0]          n_rows, n_cols;
  stage_t              stage_next;

  assign stream.ready = !rst && (!stage_valid || stage_ready);
  assign setup.ready  = !rst;
  assign fire         = stream.valid && stream.ready;
  assign cfg_fire     = setup.valid && setup.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_fire) begin
      unique case (setup.index)
        REG_FRAME_WIDTH:  frame_width  <= setup.data[CFG_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= setup.data[CFG_HEIGHT_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_BITS'(frame_width - 1'b1);
    end
    h_last = (frame_height == '0) ? '0 : ROW_BITS'(frame_height - 1'b1);
  end

  assign single_row = h_last == '0;

  // line buffers; read port always points at the next position to be used
  bmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (do_write),
    .waddr (in_col),
    .wdata (m_eff),
    .raddr (rd_addr),
    .rdata (ram_u)
  );

  bmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (do_write),
    .waddr (in_col),
    .wdata (v_in),
    .raddr (rd_addr),
    .rdata (ram_m)
  );

  assign u_eff = byp_hit ? byp_u : ram_u;
  assign m_eff = byp_hit ? byp_m : ram_m;

  assign is_sample   = stream.operation == OP_SAMPLE;
  assign v_in        = is_sample ? stream.sample : '0;
  assign release_pt  = (in_row > ROW_BITS'(1)) || (in_row == ROW_BITS'(1) && in_col != '0);
  assign final_in    = (in_row == h_last) && (in_col == w_last);
  assign out_final   = (out_row == h_last) && (out_col == w_last);
  assign col0_val    = (in_col == '0) ? stream.sample : col0;

  assign do_arrive   = fire && (is_sample != draining);
  assign do_write    = do_arrive && !(draining && single_row);
  assign dropped_res = is_sample && draining;
  assign emit        = fire && (draining || (is_sample && release_pt));
  assign adv_out     = emit && !dropped_res;
  assign last_res    = fire && !is_sample && draining && out_final;
  assign restart     = cfg_fire || last_res;

  always_comb begin
    in_col_next   = in_col;
    in_row_next   = in_row;
    out_col_next  = out_col;
    out_row_next  = out_row;
    draining_next = draining;
    if (restart) begin
      in_col_next   = '0;
      in_row_next   = '0;
      out_col_next  = '0;
      out_row_next  = '0;
      draining_next = 1'b0;
    end else begin
      if (do_write) begin
        if (in_col == w_last) begin
          in_col_next = '0;
          in_row_next = in_row + 1'b1;
        end else begin
          in_col_next = in_col + 1'b1;
        end
      end
      if (adv_out) begin
        if (out_col == w_last) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
      end
      if (fire && is_sample && !draining && final_in) begin
        draining_next = 1'b1;
      end
    end
    // a single-row frame drains by reading the column right of the output
    if (rst) begin
      rd_addr = '0;
    end else if (draining_next && single_row) begin
      rd_addr = out_col_next + 1'b1;
    end else begin
      rd_addr = in_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      draining <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      draining <= draining_next;
      byp_hit  <= do_write && (in_col == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      byp_u <= m_eff;
      byp_m <= v_in;
    end
    if (fire && is_sample && !draining && in_col == '0) begin
      col0 <= stream.sample;
    end
    if (do_arrive) begin
      win_u0 <= win_u1;
      win_m0 <= win_m1;
      win_v0 <= win_v1;
      win_u1 <= u_eff;
      win_m1 <= (is_sample && final_in && single_row) ? col0_val : m_eff;
      win_v1 <= v_in;
    end
  end

  // in-bounds masks around the output pixel
  assign r_lo = out_row != '0;
  assign r_hi = out_row != h_last;
  assign c_lo = out_col != '0;
  assign c_hi = out_col != w_last;

  assign cs0 = (r_lo ? SUM_BITS'(win_u0) : '0) + SUM_BITS'(win_m0)
             + (r_hi ? SUM_BITS'(win_v0) : '0);
  assign cs1 = (r_lo ? SUM_BITS'(win_u1) : '0) + SUM_BITS'(win_m1)
             + (r_hi ? SUM_BITS'(win_v1) : '0);
  assign cs2 = (r_lo ? SUM_BITS'(u_eff) : '0) + SUM_BITS'(m_eff)
             + (r_hi ? SUM_BITS'(v_in) : '0);
  assign sum = (c_lo ? cs0 : '0) + cs1 + (c_hi ? cs2 : '0);

  assign n_rows = 2'd1 + 2'(r_lo) + 2'(r_hi);
  assign n_cols = 2'd1 + 2'(c_lo) + 2'(c_hi);

  always_comb begin
    stage_next.frame_last = last_res;
    stage_next.dropped    = dropped_res;
    if (dropped_res) begin
      stage_next.sum   = '0;
      stage_next.count = CNT_BITS'(1);
    end else begin
      stage_next.sum   = sum;
      stage_next.count = CNT_BITS'(n_rows) * CNT_BITS'(n_cols);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid || stage_ready) begin
      stage_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stage <= stage_next;
    end
  end

endmodule

// File: rtl/bmf_mean.sv
// Rounded division of the window sum by its sample count, result register.
module bmf_mean import bmf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      stage_valid,
  input  stage_t    stage,
  output logic      stage_ready,
  bmf_out_if.source result
);

  logic [NUM_BITS-1:0]   num, quot;
  logic [RECIP_BITS-1:0] recip;
  logic [PROD_BITS-1:0]  prod;
  logic [MEAN_BITS-1:0]  mean;

  // divide by 1, 2, 3, 4, 6 or 9 through a scaled reciprocal, exact over the whole range
  assign num   = (NUM_BITS'(stage.sum) << FRAC_BITS) + NUM_BITS'(stage.count >> 1);
  assign recip = recip_of(stage.count);
  assign prod  = PROD_BITS'(num) * PROD_BITS'(recip);
  assign quot  = NUM_BITS'(prod >> DIV_SHIFT);
  assign mean  = (quot > NUM_BITS'(MEAN_MAX)) ? MEAN_MAX : MEAN_BITS'(quot);

  assign stage_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (stage_ready) begin
      result.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_ready) begin
      result.mean_value <= mean;
      result.frame_last <= stage.frame_last;
      result.dropped    <= stage.dropped;
    end
  end

endmodule

// File: rtl/box_mean_filter_3x3.sv
// Streaming 3x3 box mean filter with edge-normalized divisor.
// Each result is registered first in the window stage, then in the result register.
// One item per cycle unless the output stalls; line buffers write at most once per item.
// Reset: counters, drain state and handshakes clear; frame size returns to
// 256 x 256. Line buffers keep their contents and are not swept.
module box_mean_filter_3x3 import bmf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bmf_in_if.sink    stream,
  bmf_out_if.source result,
  bmf_cfg_if.sink   setup
);

  logic   stage_valid;
  logic   stage_ready;
  stage_t stage;

  bmf_window u_window (
    .clk         (clk),
    .rst         (rst),
    .stream      (stream),
    .setup       (setup),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  bmf_mean u_mean (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_ready (stage_ready),
    .result      (result)
  );

endmodule
